FILE: design/hsbt_pkg.sv
// Shared constants, codes, types and modular arithmetic helpers for the sorted bucket table
`timescale 1ns / 1ps
package hsbt_pkg;

	localparam int KEY_W = 40;
	localparam int VAL_W = 32;
	localparam int KEY_CHARS = 5;
	localparam int CHAR_W = 8;
	localparam int TABLE_SIZE_DEF = 128;
	localparam int BUCKET_DEPTH_DEF = 8;

	// residue width (prime is below 2**46) and signed working width
	localparam int HW = 46;
	localparam int TW = 49;
	localparam int MULT_W = 17;

	localparam logic [HW-1:0] HASH_PRIME = 46'd67280421310721;
	localparam logic [64:0] TWO_POW_64 = 65'h1_0000_0000_0000_0000;
	localparam logic [64:0] PRIME_WIDE = {19'd0, HASH_PRIME};
	// 2**64 mod prime: folds a wrapped negative sum back into range
	localparam logic [HW-1:0] WRAP_RES = HW'(TWO_POW_64 % PRIME_WIDE);

	localparam logic [HW-1:0] SEED_MULT = 46'd317665;
	localparam logic [HW-1:0] SEED_SHIFT = 46'd5;
	localparam logic [HW-1:0] SEED_DJB2 = 46'd5381;
	localparam logic [CHAR_W-1:0] CHAR_BIAS = 8'd65;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_MISS = 2'd1,
		STS_DUP  = 2'd2,
		STS_FULL = 2'd3
	} sts_t;

	typedef enum logic [1:0] {
		HSEL_MULT  = 2'd0,
		HSEL_SHIFT = 2'd1,
		HSEL_DJB2  = 2'd2
	} hsel_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_COMB,
		S_NORM,
		S_BMOD,
		S_FILL_RD,
		S_FILL_CHK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_FILL_WR,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value;
	} entry_t;

	function automatic logic [MULT_W-1:0] char_mult(input logic [2:0] i);
		logic [MULT_W-1:0] m;
		unique case (i)
			3'd0:    m = 17'd104729;
			3'd1:    m = 17'd65827;
			3'd2:    m = 17'd101749;
			3'd3:    m = 17'd37447;
			3'd4:    m = 17'd101203;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [MULT_W-1:0] hash_mult(input logic [2:0] i);
		logic [MULT_W-1:0] m;
		unique case (i)
			3'd0:    m = 17'd97103;
			3'd1:    m = 17'd95801;
			3'd2:    m = 17'd77417;
			3'd3:    m = 17'd93911;
			3'd4:    m = 17'd92959;
			default: m = '0;
		endcase
		return m;
	endfunction

	// sum of two residues, reduced once
	function automatic logic [HW-1:0] add_mod(input logic [HW-1:0] a, input logic [HW-1:0] b);
		logic [HW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, HASH_PRIME}) begin
			s = s - {1'b0, HASH_PRIME};
		end
		return s[HW-1:0];
	endfunction

	function automatic logic [HW-1:0] dbl_mod(input logic [HW-1:0] a);
		return add_mod(a, a);
	endfunction

	// bring a value in (-2p, 3p) into [0, p)
	function automatic logic [HW-1:0] norm_mod(input logic signed [TW-1:0] t);
		logic signed [TW-1:0] p1;
		logic signed [TW-1:0] p2;
		logic signed [TW-1:0] r;
		p1 = $signed(TW'(HASH_PRIME));
		p2 = p1 + p1;
		if (t < 0) begin
			r = (t + p1 < 0) ? t + p2 : t + p1;
		end else if (t >= p2) begin
			r = t - p2;
		end else if (t >= p1) begin
			r = t - p1;
		end else begin
			r = t;
		end
		return r[HW-1:0];
	endfunction

endpackage

FILE: design/hsbt_if.sv
// Valid/ready channel interfaces for table commands and responses
`timescale 1ns / 1ps
interface hsbt_req_if;
	import hsbt_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              command;
	logic [KEY_W-1:0]        key;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, command, key, value, input ready);
	modport sink (input valid, command, key, value, output ready);
endinterface

interface hsbt_rsp_if;
	import hsbt_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic [6:0]              bucket;
	logic [2:0]              position;
	logic signed [VAL_W-1:0] found_value;
	logic [31:0]             collision_count;

	modport source (output valid, status, bucket, position, found_value, collision_count,
		input ready);
	modport sink (input valid, status, bucket, position, found_value, collision_count,
		output ready);
endinterface

FILE: design/hashed_sorted_bucket_table.sv
// Hashed key/value table with sorted buckets held in synchronous memories
//
//  channel | dir | handshake        | word
//  --------+-----+------------------+-------------------------------------------------
//  req     | in  | valid/ready      | command, key, value
//  rsp     | out | valid/ready      | status, bucket, position, found_value, collisions
//  cfg     | in  | write enable     | hash_select (2 bits)
//
// One command at a time. Each of the 5 characters takes 17, 16 or 5 doubling steps for the
// table, shift-add and djb2 hashes, then a combine and a reduce step. The hash is then
// reduced to a bucket index a byte at a time, over its six bytes, and the fill count is read.
// The scan reads one slot at a time and insert or delete move one entry at a time through
// the single write port of the entry memory. After reset a clearing pass zeroes every fill
// count before the first command is taken. A waiting response does not stop the next
// command being accepted; that command stalls only when its own response is due.
`timescale 1ns / 1ps
module hashed_sorted_bucket_table #(
	parameter int TABLE_SIZE   = hsbt_pkg::TABLE_SIZE_DEF,
	parameter int BUCKET_DEPTH = hsbt_pkg::BUCKET_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata,
	hsbt_req_if.sink         req,
	hsbt_rsp_if.source       rsp
);
	import hsbt_pkg::*;

	localparam int BW    = $clog2(TABLE_SIZE);
	localparam int SLOTS = TABLE_SIZE * BUCKET_DEPTH;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW    = $clog2(BUCKET_DEPTH + 1);

	// bucket reduction: one hash byte a cycle, remainder by reciprocal multiply
	localparam int HCHUNKS = (HW + CHAR_W - 1) / CHAR_W;
	localparam int XW      = BW + CHAR_W;
	localparam int RS      = 20;
	localparam logic [RS-1:0] RECIP = RS'((1 << RS) / TABLE_SIZE);

	// memories
	entry_t         entry_mem [SLOTS];
	logic [PW-1:0]  fill_mem [TABLE_SIZE];

	state_t state_q, state_d;

	logic [1:0]              sel_q;
	logic [1:0]              cmd_q;
	logic [KEY_W-1:0]        key_q;
	logic signed [VAL_W-1:0] val_q;
	logic [HW-1:0]           h_q, d_q, a_q;
	logic signed [TW-1:0]    t_q;
	logic [2:0]              ch_q;
	logic [4:0]              step_q;
	logic [5:0]              bit_q;
	logic [BW-1:0]           b_q;
	logic [BW-1:0]           clr_q;
	logic [AW-1:0]           base_q;
	logic [PW-1:0]           fill_q, pos_q, j_q;
	logic                    hit_q;
	logic signed [VAL_W-1:0] fval_q;
	logic [1:0]              sts_q;
	logic [31:0]             col_q;
	entry_t                  entry_rd_q;
	logic [PW-1:0]           fill_rd_q;

	logic                    out_valid_q;
	logic [1:0]              out_status_q;
	logic [6:0]              out_bucket_q;
	logic [2:0]              out_position_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic [31:0]             out_col_q;

	// memory ports
	logic          entry_we;
	logic [AW-1:0] entry_waddr, entry_raddr;
	entry_t        entry_wdata;
	logic          fill_we;
	logic [BW-1:0] fill_waddr;
	logic [PW-1:0] fill_wdata;

	// decoded command and hash
	logic is_mult, is_djb2, is_ins, is_del, is_srch;
	assign is_mult = (sel_q == HSEL_MULT);
	assign is_djb2 = (sel_q == HSEL_DJB2);
	assign is_ins  = (cmd_q == CMD_INSERT);
	assign is_del  = (cmd_q == CMD_DELETE);
	assign is_srch = !is_ins && !is_del;

	logic [4:0] last_step;
	assign last_step = is_mult ? 5'd16 : (is_djb2 ? 5'd4 : 5'd15);

	// one doubling step, with a conditional add of h for the multiplicative hash
	logic [MULT_W-1:0] hm_v;
	logic [4:0]        hm_idx;
	logic [HW-1:0]     step_nx;
	always_comb begin
		hm_v    = hash_mult(ch_q);
		hm_idx  = 5'd16 - step_q;
		step_nx = dbl_mod(d_q);
		if (is_mult && hm_v[hm_idx]) begin
			step_nx = add_mod(step_nx, h_q);
		end
	end

	// fold one character into the running hash
	logic [CHAR_W-1:0]      cbyte;
	logic [24:0]            cprod;
	logic [HW-1:0]          dsum;
	logic signed [TW-1:0]   raw;
	always_comb begin
		cbyte = CHAR_W'(key_q >> (CHAR_W * (KEY_CHARS - 1 - int'(ch_q))));
		cprod = 25'(cbyte) * 25'(char_mult(ch_q));
		dsum  = add_mod(d_q, h_q);
		if (is_mult) begin
			raw = TW'(d_q) + TW'(cprod);
		end else if (is_djb2) begin
			raw = TW'(dsum ^ HW'(cbyte));
		end else begin
			raw = TW'(cbyte) - TW'(CHAR_BIAS) + TW'(a_q) + TW'(d_q) - TW'(h_q);
			if (raw < 0) begin
				raw = raw + TW'(WRAP_RES);
			end
		end
	end

	logic [HW-1:0] h_nx;
	assign h_nx = norm_mod(t_q);

	// bucket index: hash mod table size, one byte a cycle from the top
	logic [HCHUNKS*CHAR_W-1:0] h_pad;
	logic [5:0]                chunk_lo;
	logic [XW-1:0]             bm_x, bm_q, bm_r;
	logic [XW+RS-1:0]          bm_prod;
	logic [BW-1:0]             b_nx;
	always_comb begin
		h_pad    = (HCHUNKS*CHAR_W)'(h_q);
		chunk_lo = {bit_q[2:0], 3'b000};
		bm_x     = {b_q, h_pad[chunk_lo +: CHAR_W]};
		bm_prod  = (XW+RS)'(bm_x) * (XW+RS)'(RECIP);
		bm_q     = XW'(bm_prod >> RS);
		bm_r     = bm_x - bm_q * XW'(TABLE_SIZE);
		b_nx     = (bm_r >= XW'(TABLE_SIZE)) ? BW'(bm_r - XW'(TABLE_SIZE)) : BW'(bm_r);
	end

	logic [PW-1:0] fill_cl;
	assign fill_cl = (fill_rd_q > PW'(BUCKET_DEPTH)) ? PW'(BUCKET_DEPTH) : fill_rd_q;

	logic [PW:0] pos_p1, j_p2;
	logic        key_lt;
	assign pos_p1 = (PW+1)'(pos_q) + (PW+1)'(1);
	assign j_p2   = (PW+1)'(j_q) + (PW+1)'(2);
	assign key_lt = entry_rd_q.key < key_q;

	logic [31:0] b32, pos32;
	assign b32   = 32'(b_q);
	assign pos32 = 32'(pos_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == BW'(TABLE_SIZE - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req.valid) state_d = S_HASH;
			end
			S_HASH: begin
				if (step_q == last_step) state_d = S_COMB;
			end
			S_COMB: state_d = S_NORM;
			S_NORM: begin
				state_d = (ch_q == 3'(KEY_CHARS - 1)) ? S_BMOD : S_HASH;
			end
			S_BMOD: begin
				if (bit_q == '0) state_d = S_FILL_RD;
			end
			S_FILL_RD: state_d = S_FILL_CHK;
			S_FILL_CHK: begin
				state_d = (fill_cl != '0) ? S_SCAN_RD : S_DECIDE;
			end
			S_SCAN_RD: state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (key_lt && pos_p1 < (PW+1)'(fill_q)) state_d = S_SCAN_RD;
				else state_d = S_DECIDE;
			end
			S_DECIDE: begin
				priority if (is_ins) begin
					if (hit_q || fill_q == PW'(BUCKET_DEPTH)) state_d = S_RESULT;
					else if (fill_q > pos_q) state_d = S_SHIFT_RD;
					else state_d = S_PUT;
				end else if (is_del) begin
					if (!hit_q) state_d = S_RESULT;
					else if (pos_p1 < (PW+1)'(fill_q)) state_d = S_SHIFT_RD;
					else state_d = S_FILL_WR;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: begin
				if (is_ins) begin
					state_d = (j_q - PW'(1) > pos_q) ? S_SHIFT_RD : S_PUT;
				end else begin
					state_d = (j_p2 < (PW+1)'(fill_q)) ? S_SHIFT_RD : S_FILL_WR;
				end
			end
			S_PUT: state_d = S_FILL_WR;
			S_FILL_WR: state_d = S_RESULT;
			S_RESULT: begin
				if (!out_valid_q || rsp.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// handshake and memory controls
	always_comb begin
		req.ready   = 1'b0;
		entry_we    = 1'b0;
		entry_waddr = base_q + AW'(j_q);
		entry_wdata = entry_rd_q;
		entry_raddr = base_q + AW'(pos_q);
		fill_we     = 1'b0;
		fill_waddr  = b_q;
		fill_wdata  = is_ins ? fill_q + PW'(1) : fill_q - PW'(1);
		unique case (state_q)
			S_CLEAR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_q;
				fill_wdata = '0;
			end
			S_IDLE: req.ready = 1'b1;
			S_SHIFT_RD: begin
				entry_raddr = base_q + AW'(is_ins ? j_q - PW'(1) : j_q + PW'(1));
			end
			S_SHIFT_WR: entry_we = 1'b1;
			S_PUT: begin
				entry_we    = 1'b1;
				entry_waddr = base_q + AW'(pos_q);
				entry_wdata = '{key: key_q, value: val_q};
			end
			S_FILL_WR: fill_we = 1'b1;
			default: ;
		endcase
	end

	// entry memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (entry_we) entry_mem[entry_waddr] <= entry_wdata;
	end
	always_ff @(posedge clk) begin
		entry_rd_q <= entry_mem[entry_raddr];
	end

	// fill count memory
	always_ff @(posedge clk) begin
		if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
	end
	always_ff @(posedge clk) begin
		fill_rd_q <= fill_mem[b_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			sel_q       <= HSEL_SHIFT;
			clr_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) sel_q <= cfg_wdata;
			if (state_q == S_CLEAR) clr_q <= clr_q + BW'(1);
			if (state_q == S_FILL_WR && is_ins && fill_q != '0 && col_q != '1) begin
				col_q <= col_q + 32'd1;
			end
			if (state_q == S_RESULT && (!out_valid_q || rsp.ready)) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q  <= req.command;
				key_q  <= req.key;
				val_q  <= req.value;
				ch_q   <= '0;
				step_q <= '0;
				if (is_mult) begin
					h_q <= SEED_MULT;
					d_q <= '0;
				end else if (is_djb2) begin
					h_q <= SEED_DJB2;
					d_q <= SEED_DJB2;
				end else begin
					h_q <= SEED_SHIFT;
					d_q <= SEED_SHIFT;
				end
			end
			S_HASH: begin
				d_q    <= step_nx;
				step_q <= step_q + 5'd1;
				if (step_q == 5'd5) a_q <= step_nx;
			end
			S_COMB: t_q <= raw;
			S_NORM: begin
				h_q    <= h_nx;
				d_q    <= is_mult ? '0 : h_nx;
				step_q <= '0;
				ch_q   <= ch_q + 3'd1;
				b_q    <= '0;
				bit_q  <= 6'(HCHUNKS - 1);
			end
			S_BMOD: begin
				b_q   <= b_nx;
				bit_q <= bit_q - 6'd1;
			end
			S_FILL_RD: base_q <= AW'(b_q) * AW'(BUCKET_DEPTH);
			S_FILL_CHK: begin
				fill_q <= fill_cl;
				pos_q  <= '0;
				hit_q  <= 1'b0;
			end
			S_SCAN_CHK: begin
				if (key_lt) begin
					pos_q <= PW'(pos_p1);
				end else begin
					hit_q  <= (entry_rd_q.key == key_q);
					fval_q <= entry_rd_q.value;
				end
			end
			S_DECIDE: begin
				j_q <= is_ins ? fill_q : pos_q;
				if (!(is_srch && hit_q)) fval_q <= '0;
				priority if (is_ins && hit_q) sts_q <= STS_DUP;
				else if (is_ins && fill_q == PW'(BUCKET_DEPTH)) sts_q <= STS_FULL;
				else if (!is_ins && !hit_q) sts_q <= STS_MISS;
				else sts_q <= STS_OK;
			end
			S_SHIFT_WR: j_q <= is_ins ? j_q - PW'(1) : j_q + PW'(1);
			S_RESULT: begin
				if (!out_valid_q || rsp.ready) begin
					out_status_q   <= sts_q;
					out_bucket_q   <= b32[6:0];
					out_position_q <= (sts_q == STS_MISS || sts_q == STS_FULL) ? 3'd0
						: pos32[2:0];
					out_value_q    <= fval_q;
					out_col_q      <= col_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.bucket          = out_bucket_q;
	assign rsp.position        = out_position_q;
	assign rsp.found_value     = out_value_q;
	assign rsp.collision_count = out_col_q;

endmodule

FILE: design/hsbt_checker.sv
// Port-level checks for the sorted bucket table, bound to the top level
`timescale 1ns / 1ps
module hsbt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [1:0]                 rsp_status,
	input logic [2:0]                 rsp_position,
	input logic signed [hsbt_pkg::VAL_W-1:0] rsp_found_value,
	input logic [31:0]                rsp_collision_count
);
	import hsbt_pkg::*;

	// hold a stalled response: valid, status, position, value and collision count
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_position) && $stable(rsp_found_value)
			&& $stable(rsp_collision_count))
		else $error("response word changed while stalled");

	// one command in flight: ready drops after an accept
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command accepted while another is in work");

	// a miss or a full bucket reports no position and no value
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STS_MISS || rsp_status == STS_FULL)
			|-> rsp_position == 3'd0 && rsp_found_value == '0)
		else $error("miss or full response carries position or value");

	// a duplicate insert returns no value
	a_dup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STS_DUP |-> rsp_found_value == '0)
		else $error("duplicate response carries a value");

endmodule

bind hashed_sorted_bucket_table hsbt_checker u_hsbt_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_status          (rsp.status),
	.rsp_position        (rsp.position),
	.rsp_found_value     (rsp.found_value),
	.rsp_collision_count (rsp.collision_count)
);

FILE: sim/testbench.sv
// Self-checking testbench for the hashed sorted bucket table
`timescale 1ns / 1ps
module testbench;
	import hsbt_pkg::*;

	localparam int NBUCKETS = 128;
	localparam int DEPTH = 8;
	localparam logic [63:0] PRIME = 64'd67280421310721;
	localparam logic [1:0] CMD_SPARE = 2'd3;   // behaves as a search
	localparam logic [1:0] HSEL_ALIAS = 2'd3;  // behaves as shift-add

	typedef struct {
		logic [1:0]        cmd;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} table_cmd_t;

	typedef struct {
		logic [1:0]  status;
		logic [6:0]  bucket;
		logic [2:0]  position;
		logic [31:0] found;
		logic [31:0] collisions;
	} table_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_wdata = 2'd0;

	hsbt_req_if req_ch();
	hsbt_rsp_if rsp_ch();

	hashed_sorted_bucket_table u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req_ch), .rsp(rsp_ch)
	);

	always #6 clk = ~clk;

	// mirror of the table contents
	logic [KEY_W-1:0] mirror_keys [NBUCKETS][DEPTH];
	logic [VAL_W-1:0] mirror_vals [NBUCKETS][DEPTH];
	int unsigned mirror_fill [NBUCKETS];
	logic [31:0] mirror_colls = '0;
	logic [1:0] mirror_hsel = HSEL_SHIFT;

	table_cmd_t cmd_queue [$];
	table_rsp_t pending_rsps [$];
	table_cmd_t cur_cmd;
	bit steady = 1'b0;
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;

	function automatic logic [63:0] key_hash(logic [KEY_W-1:0] key, logic [1:0] sel);
		logic [63:0] cm [5];
		logic [63:0] hm [5];
		logic [63:0] h;
		logic [63:0] c;
		cm = '{64'd104729, 64'd65827, 64'd101749, 64'd37447, 64'd101203};
		hm = '{64'd97103, 64'd95801, 64'd77417, 64'd93911, 64'd92959};
		if (sel == HSEL_MULT) begin
			h = (64'd5 * 64'd63533) % PRIME;
			for (int i = 0; i < 5; i++) begin
				c = 64'(key[8*(4-i) +: 8]);
				h = ((h * hm[i]) % PRIME + (c * cm[i]) % PRIME) % PRIME;
			end
		end else if (sel == HSEL_DJB2) begin
			h = 64'd5381;
			for (int i = 0; i < 5; i++)
				h = ((((h << 5) + h) % PRIME) ^ 64'(key[8*(4-i) +: 8])) % PRIME;
		end else begin
			h = 64'd5;
			for (int i = 0; i < 5; i++) begin
				c = 64'(key[8*(4-i) +: 8]) - 64'd65;
				h = (c + ((h << 6) % PRIME) + ((h << 16) % PRIME) - (h % PRIME)) % PRIME;
			end
		end
		return h;
	endfunction

	function automatic int unsigned bucket_of(logic [KEY_W-1:0] key);
		return int'(key_hash(key, mirror_hsel) % NBUCKETS);
	endfunction

	// apply one command to the mirror and return the response it must produce
	function automatic table_rsp_t apply_command(table_cmd_t c);
		table_rsp_t r;
		int unsigned b, fill, pos;
		bit hit;
		b = bucket_of(c.key);
		fill = mirror_fill[b];
		pos = 0;
		while (pos < fill && mirror_keys[b][pos] < c.key)
			pos++;
		hit = (pos < fill) && (mirror_keys[b][pos] == c.key);
		r = '{STS_OK, 7'(b), 3'd0, 32'd0, 32'd0};
		if (c.cmd == CMD_INSERT) begin
			if (hit) begin
				r.status = STS_DUP;
				r.position = 3'(pos);
			end else if (fill >= DEPTH) begin
				r.status = STS_FULL;
			end else begin
				for (int j = fill; j > pos; j--) begin
					mirror_keys[b][j] = mirror_keys[b][j-1];
					mirror_vals[b][j] = mirror_vals[b][j-1];
				end
				mirror_keys[b][pos] = c.key;
				mirror_vals[b][pos] = c.value;
				if (fill != 0 && mirror_colls != 32'hFFFF_FFFF)
					mirror_colls++;
				mirror_fill[b] = fill + 1;
				r.position = 3'(pos);
			end
		end else if (c.cmd == CMD_DELETE) begin
			if (!hit) begin
				r.status = STS_MISS;
			end else begin
				for (int j = pos; j + 1 < fill; j++) begin
					mirror_keys[b][j] = mirror_keys[b][j+1];
					mirror_vals[b][j] = mirror_vals[b][j+1];
				end
				mirror_fill[b] = fill - 1;
				r.position = 3'(pos);
			end
		end else begin
			if (!hit) begin
				r.status = STS_MISS;
			end else begin
				r.position = 3'(pos);
				r.found = mirror_vals[b][pos];
			end
		end
		r.collisions = mirror_colls;
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] letter_key();
		logic [KEY_W-1:0] k;
		for (int i = 0; i < 5; i++)
			k[8*i +: 8] = 8'($urandom_range(65, 90));
		return k;
	endfunction

	// letter keys that all land in one bucket under the current hash
	function automatic void same_bucket_keys(int n, ref logic [KEY_W-1:0] keys [$]);
		logic [KEY_W-1:0] k;
		int unsigned target;
		target = bucket_of(letter_key());
		while (keys.size() < n) begin
			k = letter_key();
			if (bucket_of(k) == target)
				keys.insert(keys.size(), k);
		end
	endfunction

	function automatic void queue_word(logic [1:0] cmd, logic [KEY_W-1:0] key,
		logic [VAL_W-1:0] value);
		table_cmd_t c;
		c.cmd = cmd;
		c.key = key;
		c.value = value;
		cmd_queue.insert(cmd_queue.size(), c);
	endfunction

	// request driver: predict on acceptance, then load the next word or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				pending_rsps.insert(pending_rsps.size(), apply_command(cur_cmd));
				words_sent++;
			end
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (cmd_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 31)) begin
					cur_cmd = cmd_queue.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.command <= cur_cmd.cmd;
					req_ch.key <= cur_cmd.key;
					req_ch.value <= cur_cmd.value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor: compare each accepted word with the oldest prediction
	always @(posedge clk) begin
		table_rsp_t e;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_rsps.size() == 0) begin
					$error("response word with no command outstanding");
					errors++;
				end else begin
					e = pending_rsps.pop_front();
					words_checked++;
					if (rsp_ch.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, rsp_ch.status);
						errors++;
					end
					if (rsp_ch.bucket !== e.bucket) begin
						$error("bucket: expected %0d, got %0d", e.bucket, rsp_ch.bucket);
						errors++;
					end
					if (rsp_ch.position !== e.position) begin
						$error("position: expected %0d, got %0d", e.position, rsp_ch.position);
						errors++;
					end
					if (rsp_ch.found_value !== e.found) begin
						$error("found_value: expected %0d, got %0d", $signed(e.found),
							rsp_ch.found_value);
						errors++;
					end
					if (rsp_ch.collision_count !== e.collisions) begin
						$error("collision_count: expected %0d, got %0d", e.collisions,
							rsp_ch.collision_count);
						errors++;
					end
				end
			end
			rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 31);
		end
	end

	task automatic drain();
		while (cmd_queue.size() != 0 || req_ch.valid || pending_rsps.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_hash(logic [1:0] sel);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= sel;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror_hsel = sel;
	endtask

	// random traffic over a small key pool with one crowded bucket, plus some keys outside it
	task automatic random_phase(int n);
		logic [KEY_W-1:0] pool [$];
		logic [KEY_W-1:0] k;
		int r;
		same_bucket_keys(11, pool);
		repeat (29) pool.insert(pool.size(), letter_key());
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 6)
				k = {$urandom(), 8'($urandom())};
			else
				k = pool[$urandom_range(0, pool.size() - 1)];
			r = $urandom_range(0, 99);
			if (r < 45)
				queue_word(CMD_INSERT, k, $urandom());
			else if (r < 70)
				queue_word(CMD_SEARCH, k, $urandom());
			else if (r < 94)
				queue_word(CMD_DELETE, k, $urandom());
			else
				queue_word(CMD_SPARE, k, $urandom());
		end
		drain();
	endtask

	initial begin
		logic [KEY_W-1:0] crowd [$];
		req_ch.valid = 1'b0;
		req_ch.command = CMD_SEARCH;
		req_ch.key = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		for (int b = 0; b < NBUCKETS; b++)
			mirror_fill[b] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: duplicates, misses, extremes, spare command, full bucket
		queue_word(CMD_INSERT, "AAAAA", 32'h7FFF_FFFF);
		queue_word(CMD_INSERT, "AAAAA", 32'h1234_5678);
		queue_word(CMD_SEARCH, "AAAAA", 32'h0);
		queue_word(CMD_SEARCH, "ZZZZZ", 32'hFFFF_FFFF);
		queue_word(CMD_INSERT, "ZZZZZ", 32'h8000_0000);
		queue_word(CMD_SPARE, "ZZZZZ", 32'h0);
		queue_word(CMD_INSERT, 40'h00_0000_0000, 32'hFFFF_FFFF);
		queue_word(CMD_INSERT, 40'hFF_FFFF_FFFF, 32'h5555_AAAA);
		queue_word(CMD_SEARCH, 40'hFF_FFFF_FFFF, 32'h0);
		queue_word(CMD_DELETE, "AAAAA", 32'h0);
		queue_word(CMD_DELETE, "AAAAA", 32'h0);
		same_bucket_keys(9, crowd);
		foreach (crowd[i])
			queue_word(CMD_INSERT, crowd[i], $urandom());
		queue_word(CMD_DELETE, crowd[3], 32'h0);
		queue_word(CMD_SEARCH, crowd[8], 32'h0);
		drain();

		random_phase(300);
		set_hash(HSEL_MULT);
		random_phase(300);
		set_hash(HSEL_DJB2);
		steady = 1'b1;
		random_phase(300);
		steady = 1'b0;
		set_hash(HSEL_ALIAS);
		random_phase(200);
		set_hash(HSEL_SHIFT);
		random_phase(100);

		repeat (300) @(posedge clk);
		$display("Checked %0d of %0d responses over all four hash settings,", words_checked,
			words_sent);
		$display("with duplicates, misses, full buckets and shifted entries; %0d errors.",
			errors);
		if (errors == 0 && pending_rsps.size() == 0)
			$display("PASS hashed_sorted_bucket_table");
		else
			$display("FAIL hashed_sorted_bucket_table");
		$finish;
	end

	// hang guard
	initial begin
		#50ms;
		$display("FAIL hashed_sorted_bucket_table");
		$finish;
	end
endmodule

FILE: files.f
design/hsbt_pkg.sv
design/hsbt_if.sv
design/hashed_sorted_bucket_table.sv
design/hsbt_checker.sv
sim/testbench.sv
